/* hw/rtl/xcsd_pkg.sv */
package xcsd_pkg;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_SUM   = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic [1:0] ST_ABSORB = 2'd0;
    localparam logic [1:0] ST_FRAME  = 2'd1;
    localparam logic [1:0] ST_ERROR  = 2'd2;

    localparam logic [2:0] TY_UNKNOWN = 3'd0;
    localparam logic [2:0] TY_CHA     = 3'd1;
    localparam logic [2:0] TY_ACC     = 3'd2;
    localparam logic [2:0] TY_REV     = 3'd3;
    localparam logic [2:0] TY_SHO     = 3'd4;
    localparam logic [2:0] TY_RES     = 3'd5;

    localparam logic [23:0] HD_CHA = 24'h434841;
    localparam logic [23:0] HD_ACC = 24'h414343;
    localparam logic [23:0] HD_REV = 24'h524556;
    localparam logic [23:0] HD_SHO = 24'h53484F;
    localparam logic [23:0] HD_RES = 24'h524553;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

endpackage

/* hw/rtl/xcsd_char_dec.sv */
module xcsd_char_dec (
    input  logic [7:0]         i_byte,
    input  logic [23:0]        i_head,
    output xcsd_pkg::t_hex     o_hex,
    output logic [2:0]         o_msg_type
);
    import xcsd_pkg::*;

    always_comb begin
        o_hex = '{is_hex: 1'b0, value: 4'd0};
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            o_hex.is_hex = 1'b1;
            o_hex.value  = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h61 && i_byte <= 8'h66) begin
            o_hex.is_hex = 1'b1;
            o_hex.value  = 4'(i_byte - 8'h57);
        end
    end

    always_comb begin
        unique case (i_head)
            HD_CHA:  o_msg_type = TY_CHA;
            HD_ACC:  o_msg_type = TY_ACC;
            HD_REV:  o_msg_type = TY_REV;
            HD_SHO:  o_msg_type = TY_SHO;
            HD_RES:  o_msg_type = TY_RES;
            default: o_msg_type = TY_UNKNOWN;
        endcase
    end

endmodule

/* hw/rtl/xor_checked_sentence_deframer_unit.sv */
// Each accepted input byte yields a result beat in the cycle after it is taken.
// One byte per cycle unless output stalls; the result register frees once taken.
// Each byte is compared, then XORed or nibble-shifted, before the registers.
// Reset (synchronous, active low): phase returns to waiting for the start
// delimiter, all accumulators clear, and no result is pending.
module xor_checked_sentence_deframer_unit #(
    parameter int MAX_PAYLOAD = 128,
    parameter int SUM_DIGITS  = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_frame_status,
    output logic [2:0] o_msg_type,
    output logic [7:0] o_payload_len
);
    import xcsd_pkg::*;

    localparam logic [7:0] LP_MAX_PAYLOAD = 8'(MAX_PAYLOAD);
    localparam logic [1:0] LP_SUM_DIGITS  = 2'(SUM_DIGITS);

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SUM     = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_xor, n_xor;
    logic [7:0]  r_count, n_count;
    logic [23:0] r_head, n_head;
    logic [7:0]  r_sum, n_sum;
    logic [1:0]  r_digits, n_digits;

    logic        r_out_valid;
    logic [1:0]  r_status, n_status;
    logic [2:0]  r_type, n_type;
    logic [7:0]  r_len, n_len;

    t_hex        w_hex;
    logic [2:0]  w_type;
    logic        w_accept;

    xcsd_char_dec u_char_dec (
        .i_byte     (i_in_byte),
        .i_head     (r_head),
        .o_hex      (w_hex),
        .o_msg_type (w_type)
    );

    assign o_in_ready     = !r_out_valid || i_out_ready;
    assign w_accept       = i_in_valid && o_in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_frame_status = r_status;
    assign o_msg_type     = r_type;
    assign o_payload_len  = r_len;

    always_comb begin
        n_phase  = r_phase;
        n_xor    = r_xor;
        n_count  = r_count;
        n_head   = r_head;
        n_sum    = r_sum;
        n_digits = r_digits;
        n_status = ST_ABSORB;
        n_type   = TY_UNKNOWN;
        n_len    = 8'd0;
        unique case (r_phase)
            PH_PAYLOAD: begin
                if (i_in_byte == CH_START || i_in_byte == CH_NL) begin
                    if (i_in_byte == CH_START) begin
                        n_xor    = 8'd0;
                        n_count  = 8'd0;
                        n_head   = 24'd0;
                        n_sum    = 8'd0;
                        n_digits = 2'd0;
                    end
                    n_status = ST_ERROR;
                    n_phase  = PH_WAIT;
                end else if (i_in_byte == CH_SUM) begin
                    n_sum    = 8'd0;
                    n_digits = 2'd0;
                    n_phase  = PH_SUM;
                end else if (r_count >= LP_MAX_PAYLOAD) begin
                    n_status = ST_ERROR;
                    n_phase  = PH_WAIT;
                end else begin
                    n_xor = r_xor ^ i_in_byte;
                    if (r_count < 8'd3) begin
                        n_head = {r_head[15:0], i_in_byte};
                    end
                    n_count = r_count + 8'd1;
                end
            end
            PH_SUM: begin
                if (w_hex.is_hex) begin
                    if (r_digits >= LP_SUM_DIGITS) begin
                        n_status = ST_ERROR;
                        n_phase  = PH_WAIT;
                    end else begin
                        n_sum    = {r_sum[3:0], w_hex.value};
                        n_digits = r_digits + 2'd1;
                    end
                end else if (i_in_byte == CH_NL) begin
                    if (r_digits != 2'd0 && r_sum == r_xor) begin
                        n_status = ST_FRAME;
                        n_type   = w_type;
                        n_len    = r_count;
                    end else begin
                        n_status = ST_ERROR;
                    end
                    n_phase = PH_WAIT;
                end else begin
                    n_status = ST_ERROR;
                    n_phase  = PH_WAIT;
                end
            end
            default: begin
                n_phase = PH_WAIT;
                if (i_in_byte == CH_START) begin
                    n_xor    = 8'd0;
                    n_count  = 8'd0;
                    n_head   = 24'd0;
                    n_sum    = 8'd0;
                    n_digits = 2'd0;
                    n_phase  = PH_PAYLOAD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_xor       <= 8'd0;
            r_count     <= 8'd0;
            r_head      <= 24'd0;
            r_sum       <= 8'd0;
            r_digits    <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase  <= n_phase;
                r_xor    <= n_xor;
                r_count  <= n_count;
                r_head   <= n_head;
                r_sum    <= n_sum;
                r_digits <= n_digits;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_type   <= n_type;
            r_len    <= n_len;
        end
    end

    a_no_type_off_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_status != ST_FRAME |-> o_msg_type == TY_UNKNOWN
            && o_payload_len == 8'd0)
        else $error("type or length set on a beat that is not a valid frame");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LP_MAX_PAYLOAD)
        else $error("payload count beyond limit");

    a_start_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_phase == PH_WAIT && i_in_byte == CH_START
            |=> r_phase == PH_PAYLOAD && r_count == 8'd0 && r_xor == 8'd0)
        else $error("start delimiter did not open a cleared payload");

    a_frame_needs_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_status == ST_FRAME |-> r_digits != 2'd0 && r_phase == PH_SUM)
        else $error("frame completed without checksum digits");

endmodule
